[src/crcq_pkg.sv]
// Package for the CAN receive class queues block.
// Holds field widths, action codes, register indexes and controller/datapath structs.
// Has no dependencies; every other file but crcq_ram uses it.
`default_nettype none
package crcq_pkg;

  localparam int ID_W   = 29;
  localparam int STD_W  = 11;
  localparam int DLC_W  = 4;
  localparam int DATA_W = 64;
  localparam int HDR_W  = ID_W + 1 + DLC_W;

  localparam logic [1:0] ACT_RECEIVE  = 2'd0;
  localparam logic [1:0] ACT_POP_EXT  = 2'd1;
  localparam logic [1:0] ACT_POP_DIAG = 2'd2;

  localparam logic CFG_DIAG_PHYS = 1'b0;
  localparam logic CFG_DIAG_FUNC = 1'b1;

  localparam logic [STD_W-1:0] DIAG_PHYS_RST = 11'h7E0;
  localparam logic [STD_W-1:0] DIAG_FUNC_RST = 11'h7DF;

  typedef struct packed {
    logic accept;
    logic load_direct;
    logic load_mem;
  } crcq_cmd_t;

  typedef struct packed {
    logic pop_hit;
  } crcq_sts_t;

endpackage
`default_nettype wire

[src/crcq_in_if.sv]
// Input channel interface: valid/ready handshake with one request item.
// Depends on crcq_pkg for field widths.
`default_nettype none
interface crcq_in_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  action;
  logic                        bus;
  logic [crcq_pkg::ID_W-1:0]   frame_id;
  logic                        is_extended;
  logic [crcq_pkg::DLC_W-1:0]  length_code;
  logic [crcq_pkg::DATA_W-1:0] payload;

  modport source (output valid, action, bus, frame_id, is_extended, length_code, payload,
                  input ready);
  modport sink (input valid, action, bus, frame_id, is_extended, length_code, payload,
                output ready);
endinterface
`default_nettype wire

[src/crcq_out_if.sv]
// Result channel interface: valid/ready handshake with one result item.
// Depends on crcq_pkg for field widths.
`default_nettype none
interface crcq_out_if;
  logic                        valid;
  logic                        ready;
  logic                        ok;
  logic [crcq_pkg::ID_W-1:0]   out_id;
  logic                        out_extended;
  logic [crcq_pkg::DLC_W-1:0]  out_length_code;
  logic [crcq_pkg::DATA_W-1:0] out_payload;

  modport source (output valid, ok, out_id, out_extended, out_length_code, out_payload,
                  input ready);
  modport sink (input valid, ok, out_id, out_extended, out_length_code, out_payload,
                output ready);
endinterface
`default_nettype wire

[src/can_rx_class_queues_top.sv]
// Top level of the CAN receive class queues block.
// Depends on crcq_pkg, crcq_in_if, crcq_out_if, crcq_ctrl and crcq_dp.
//
//   Channel  Direction  Handshake          Contents
//   in_ch    sink       valid/ready        action, bus, frame_id, is_extended, length_code, payload
//   out_ch   source     valid/ready        ok, out_id, out_extended, out_length_code, out_payload
//   cfg_*    sink       cfg_we only        cfg_index selects diagnostic ID, cfg_wdata 11 bits
//
// A receive item or a pop that finds its queue empty loads the result register directly; a
// successful pop first goes through the registered read of the frame store.
// The result register frees in the cycle it is taken, so a new item can be accepted then.
// Reset is synchronous; it clears queue pointers and presets the diagnostic IDs, not the store.
// A stalled result holds off the next input item.
`default_nettype none
module can_rx_class_queues_top #(
  parameter int QUEUE_DEPTH = 32,
  parameter int BUS_COUNT   = 2
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_we,
  input  wire logic                       cfg_index,
  input  wire logic [crcq_pkg::STD_W-1:0] cfg_wdata,
  crcq_in_if.sink                         in_ch,
  crcq_out_if.source                      out_ch
);
  import crcq_pkg::*;

  crcq_cmd_t cmd;
  crcq_sts_t sts;

  crcq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  crcq_dp #(.QUEUE_DEPTH(QUEUE_DEPTH), .BUS_COUNT(BUS_COUNT)) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .action          (in_ch.action),
    .bus             (in_ch.bus),
    .frame_id        (in_ch.frame_id),
    .is_extended     (in_ch.is_extended),
    .length_code     (in_ch.length_code),
    .payload         (in_ch.payload),
    .cmd             (cmd),
    .sts             (sts),
    .ok              (out_ch.ok),
    .out_id          (out_ch.out_id),
    .out_extended    (out_ch.out_extended),
    .out_length_code (out_ch.out_length_code),
    .out_payload     (out_ch.out_payload)
  );

endmodule
`default_nettype wire

[src/crcq_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module crcq_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [$clog2(D)-1:0] waddr,
  input  wire logic [W-1:0]         wdata,
  input  wire logic                 re,
  input  wire logic [$clog2(D)-1:0] raddr,
  output logic      [W-1:0]         rdata
);

  logic [W-1:0] mem_r [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule
`default_nettype wire

[src/crcq_ctrl.sv]
// Controller state machine: input and result handshakes, memory-read sequencing.
// Depends on crcq_pkg for the command and status structs.
`default_nettype none
module crcq_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  output logic                     out_valid,
  input  wire logic                out_ready,
  input  wire crcq_pkg::crcq_sts_t sts,
  output crcq_pkg::crcq_cmd_t      cmd
);
  import crcq_pkg::*;

  typedef enum logic {ST_IDLE, ST_READ} state_t;

  state_t state_r;
  logic   out_valid_r;
  logic   out_free;

  assign out_free        = !out_valid_r || out_ready;
  assign in_ready        = (state_r == ST_IDLE) && out_free;
  assign cmd.accept      = in_ready && in_valid;
  assign cmd.load_direct = cmd.accept && !sts.pop_hit;
  assign cmd.load_mem    = (state_r == ST_READ);
  assign out_valid       = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (cmd.accept && sts.pop_hit) begin
            state_r     <= ST_READ;
            out_valid_r <= 1'b0;
          end else if (cmd.accept) begin
            out_valid_r <= 1'b1;
          end else if (out_ready) begin
            out_valid_r <= 1'b0;
          end
        end
        ST_READ: begin
          state_r     <= ST_IDLE;
          out_valid_r <= 1'b1;
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  a_read_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_READ) |-> !out_valid_r)
    else $error("Result register occupied during memory read.");

  a_pop_goes_read: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.accept && sts.pop_hit) |=> (state_r == ST_READ))
    else $error("Successful pop did not enter the read state.");
`endif

endmodule
`default_nettype wire

[src/crcq_dp.sv]
// Datapath: diagnostic ID registers, queue pointers, frame stores and result register.
// Depends on crcq_pkg and crcq_ram.
`default_nettype none
module crcq_dp #(
  parameter int QUEUE_DEPTH = 32,
  parameter int BUS_COUNT   = 2
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic                          cfg_index,
  input  wire logic [crcq_pkg::STD_W-1:0]    cfg_wdata,
  input  wire logic [1:0]                    action,
  input  wire logic                          bus,
  input  wire logic [crcq_pkg::ID_W-1:0]     frame_id,
  input  wire logic                          is_extended,
  input  wire logic [crcq_pkg::DLC_W-1:0]    length_code,
  input  wire logic [crcq_pkg::DATA_W-1:0]   payload,
  input  wire crcq_pkg::crcq_cmd_t           cmd,
  output crcq_pkg::crcq_sts_t                sts,
  output logic                               ok,
  output logic [crcq_pkg::ID_W-1:0]          out_id,
  output logic                               out_extended,
  output logic [crcq_pkg::DLC_W-1:0]         out_length_code,
  output logic [crcq_pkg::DATA_W-1:0]        out_payload
);
  import crcq_pkg::*;

  localparam int QUEUE_COUNT = 2 * BUS_COUNT;
  localparam int QW          = $clog2(QUEUE_COUNT);
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int SLOTS       = QUEUE_COUNT * QUEUE_DEPTH;
  localparam int AW          = $clog2(SLOTS);
  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [AW-1:0]    DEPTH_A   = AW'(QUEUE_DEPTH);

  logic [STD_W-1:0]  diag_phys_r;
  logic [STD_W-1:0]  diag_func_r;
  logic [PTR_W-1:0]  wp_r [QUEUE_COUNT];
  logic [PTR_W-1:0]  rp_r [QUEUE_COUNT];

  logic              bus_ok;
  logic              is_pop;
  logic              diag_match;
  logic              sel;
  logic [QW-1:0]     q;
  logic [PTR_W-1:0]  wp;
  logic [PTR_W-1:0]  rp;
  logic [PTR_W-1:0]  wp_inc;
  logic [PTR_W-1:0]  rp_inc;
  logic              push_ok;
  logic              pop_ok;
  logic [PTR_W-1:0]  slot;
  logic [AW-1:0]     addr;
  logic              ram_we;
  logic              ram_re;
  logic [HDR_W-1:0]  hdr_wdata;
  logic [HDR_W-1:0]  hdr_rdata;
  logic [DATA_W-1:0] data_rdata;

  logic              ok_r;
  logic [ID_W-1:0]   id_r;
  logic              ext_r;
  logic [DLC_W-1:0]  dlc_r;
  logic [DATA_W-1:0] data_r;

  assign bus_ok     = (32'(bus) < BUS_COUNT);
  assign is_pop     = (action == ACT_POP_EXT) || (action == ACT_POP_DIAG);
  assign diag_match = (frame_id == {{(ID_W-STD_W){1'b0}}, diag_phys_r})
                   || (frame_id == {{(ID_W-STD_W){1'b0}}, diag_func_r});
  assign sel        = is_pop ? (action == ACT_POP_DIAG) : !is_extended;
  assign q          = QW'({bus, sel});
  assign wp         = wp_r[q];
  assign rp         = rp_r[q];
  assign wp_inc     = (wp == LAST_SLOT) ? '0 : wp + 1'b1;
  assign rp_inc     = (rp == LAST_SLOT) ? '0 : rp + 1'b1;

  assign push_ok    = (action == ACT_RECEIVE) && bus_ok && (is_extended || diag_match)
                   && (wp_inc != rp);
  assign pop_ok     = is_pop && bus_ok && (rp != wp);
  assign sts.pop_hit = pop_ok;

  assign slot      = is_pop ? rp : wp;
  assign addr      = AW'(q) * DEPTH_A + AW'(slot);
  assign ram_we    = cmd.accept && push_ok;
  assign ram_re    = cmd.accept && pop_ok;
  assign hdr_wdata = {length_code, is_extended, frame_id};

  crcq_ram #(.W(HDR_W), .D(SLOTS)) u_header_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (addr),
    .wdata (hdr_wdata),
    .re    (ram_re),
    .raddr (addr),
    .rdata (hdr_rdata)
  );

  crcq_ram #(.W(DATA_W), .D(SLOTS)) u_payload_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (addr),
    .wdata (payload),
    .re    (ram_re),
    .raddr (addr),
    .rdata (data_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      diag_phys_r <= DIAG_PHYS_RST;
      diag_func_r <= DIAG_FUNC_RST;
      for (int i = 0; i < QUEUE_COUNT; i++) begin
        wp_r[i] <= '0;
        rp_r[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_DIAG_PHYS: diag_phys_r <= cfg_wdata;
          CFG_DIAG_FUNC: diag_func_r <= cfg_wdata;
          default: begin
          end
        endcase
      end
      if (ram_we) begin
        wp_r[q] <= wp_inc;
      end
      if (ram_re) begin
        rp_r[q] <= rp_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_direct) begin
      ok_r   <= push_ok;
      id_r   <= '0;
      ext_r  <= 1'b0;
      dlc_r  <= '0;
      data_r <= '0;
    end else if (cmd.load_mem) begin
      ok_r   <= 1'b1;
      id_r   <= hdr_rdata[ID_W-1:0];
      ext_r  <= hdr_rdata[ID_W];
      dlc_r  <= hdr_rdata[HDR_W-1:ID_W+1];
      data_r <= data_rdata;
    end
  end

  assign ok              = ok_r;
  assign out_id          = id_r;
  assign out_extended    = ext_r;
  assign out_length_code = dlc_r;
  assign out_payload     = data_r;

`ifndef SYNTH
  a_mem_load_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_mem |-> $past(ram_re))
    else $error("Result loaded from memory without a preceding read.");

  a_ptr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(wp) < QUEUE_DEPTH) && (32'(rp) < QUEUE_DEPTH))
    else $error("Queue pointer outside the queue depth.");
`endif

endmodule
`default_nettype wire
